### rtl/dcsum_pkg.sv
// Shared constants, types and helper functions of the duty-cycled sensor averager.
package dcsum_pkg;

   // Sizing of the sample store, the converter word and the tick timer.
   localparam int MAX_SAMPLES = 16;
   localparam int ADC_BITS = 12;
   localparam int TIME_BITS = 16;

   localparam int CNT_BITS = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_BITS = $clog2(MAX_SAMPLES);
   localparam int HALF_BITS = $clog2(MAX_SAMPLES / 2 + 1);
   localparam int SUM_BITS = ADC_BITS + HALF_BITS;
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

   // Register port geometry.
   localparam int SCNT_BITS = 5;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_WARM = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WARM = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLEEP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT = 3'd4;

   // Register values after reset.
   localparam logic [TIME_BITS-1:0] INIT_WARM_RESET = TIME_BITS'(60);
   localparam logic [TIME_BITS-1:0] WARM_RESET = TIME_BITS'(30);
   localparam logic [TIME_BITS-1:0] INTERVAL_RESET = TIME_BITS'(1);
   localparam logic [TIME_BITS-1:0] SLEEP_RESET = TIME_BITS'(60);
   localparam logic [SCNT_BITS-1:0] COUNT_RESET = SCNT_BITS'(10);

   typedef logic [ADC_BITS-1:0] adc_type;
   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [CNT_BITS-1:0] cnt_type;
   typedef logic [HALF_BITS-1:0] half_type;
   typedef logic [SUM_BITS-1:0] sum_type;

   typedef enum logic [1:0] {
      PH_INIT_WARM,
      PH_WARM,
      PH_SAMPLE,
      PH_SLEEP
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SUM,
      CTL_DIV,
      CTL_OUT
   } ctl_state_type;

   typedef enum logic {
      SEL_IDLE,
      SEL_SCAN
   } sel_state_type;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   // Job handed to the selection unit: entries held and how many largest to add.
   typedef struct packed {
      cnt_type  count;
      half_type half;
   } sel_cmd_type;

   // Samples per burst, clamped to the range the store supports.
   function automatic cnt_type burst_size(logic [SCNT_BITS-1:0] sc);
      cnt_type n;
      if (int'(sc) < 2) begin
         n = CNT_BITS'(2);
      end else if (int'(sc) > MAX_SAMPLES) begin
         n = CNT_BITS'(MAX_SAMPLES);
      end else begin
         n = CNT_BITS'(sc);
      end
      return n;
   endfunction

endpackage

### rtl/dcsum_req_if.sv
// Tick channel carrying one converter reading per transfer.
interface dcsum_req_if;
   import dcsum_pkg::*;

   logic    valid;
   logic    ready;
   adc_type adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

### rtl/dcsum_rsp_if.sv
// Result channel carrying the status and average of one tick per transfer.
interface dcsum_rsp_if;
   import dcsum_pkg::*;

   logic    valid;
   logic    ready;
   logic    power_on;
   logic    sample_taken;
   logic    new_average;
   logic    average_valid;
   adc_type average_value;

   modport source (output valid, output power_on, output sample_taken, output new_average,
                   output average_valid, output average_value, input ready);
   modport sink (input valid, input power_on, input sample_taken, input new_average,
                 input average_valid, input average_value, output ready);
endinterface

### rtl/dcsum_sample_ram.sv
// Burst sample store: one write port, one read port with registered read data.
module dcsum_sample_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [dcsum_pkg::IDX_BITS-1:0] wr_addr,
   input  dcsum_pkg::adc_type           wr_data,
   input  logic [dcsum_pkg::IDX_BITS-1:0] rd_addr,
   output dcsum_pkg::adc_type           rd_data
);
   import dcsum_pkg::*;

   adc_type mem [MAX_SAMPLES];
   adc_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/dcsum_select.sv
// Selection unit: sums the largest entries of the store, one scan of the memory per pick.
module dcsum_select (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  dcsum_pkg::sel_cmd_type         cmd,
   output logic [dcsum_pkg::IDX_BITS-1:0] rd_addr,
   input  dcsum_pkg::adc_type             rd_data,
   output logic                           done,
   output dcsum_pkg::sum_type             sum
);
   import dcsum_pkg::*;

   sel_state_type            state_ff, state_in;
   cnt_type                  count_ff, count_in;
   half_type                 half_ff, half_in;
   cnt_type                  issue_ff, issue_in;
   logic [IDX_BITS-1:0]      tag_ff, tag_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [MAX_SAMPLES-1:0]   picked_ff, picked_in;
   adc_type                  best_val_ff, best_val_in;
   logic [IDX_BITS-1:0]      best_idx_ff, best_idx_in;
   logic                     found_ff, found_in;
   half_type                 pass_ff, pass_in;
   sum_type                  sum_ff, sum_in;
   logic                     done_ff, done_in;

   logic                     issue_en;
   logic                     better;
   logic                     pass_end;
   cnt_type                  last_idx;
   adc_type                  pick_val;
   logic [IDX_BITS-1:0]      pick_idx;

   assign rd_addr = issue_ff[IDX_BITS-1:0];
   assign done = done_ff;
   assign sum = sum_ff;

   // Each pass reads every held entry and keeps the largest one not yet picked;
   // ties go to the lowest address. The pass ends when the last read returns.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      half_in = half_ff;
      issue_in = issue_ff;
      tag_in = tag_ff;
      rd_valid_in = 1'b0;
      picked_in = picked_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      found_in = found_ff;
      pass_in = pass_ff;
      sum_in = sum_ff;
      done_in = 1'b0;

      issue_en = (state_ff == SEL_SCAN) && (issue_ff < count_ff);
      last_idx = count_ff - CNT_BITS'(1);
      better = rd_valid_ff && !picked_ff[tag_ff] && (!found_ff || (rd_data > best_val_ff));
      pick_val = better ? rd_data : best_val_ff;
      pick_idx = better ? tag_ff : best_idx_ff;
      pass_end = rd_valid_ff && (tag_ff == last_idx[IDX_BITS-1:0]);

      case (state_ff)
         SEL_IDLE: begin
            if (start) begin
               state_in = SEL_SCAN;
               count_in = cmd.count;
               half_in = cmd.half;
               issue_in = '0;
               picked_in = '0;
               found_in = 1'b0;
               pass_in = '0;
               sum_in = '0;
            end
         end
         SEL_SCAN: begin
            rd_valid_in = issue_en;
            tag_in = issue_ff[IDX_BITS-1:0];
            if (issue_en) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end
            if (better) begin
               best_val_in = rd_data;
               best_idx_in = tag_ff;
               found_in = 1'b1;
            end
            if (pass_end) begin
               sum_in = sum_ff + SUM_BITS'(pick_val);
               picked_in[pick_idx] = 1'b1;
               found_in = 1'b0;
               issue_in = '0;
               pass_in = pass_ff + HALF_BITS'(1);
               if (pass_ff + HALF_BITS'(1) == half_ff) begin
                  done_in = 1'b1;
                  state_in = SEL_IDLE;
               end
            end
         end
         default: begin
            state_in = SEL_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEL_IDLE;
         rd_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_valid_ff <= rd_valid_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      half_ff <= half_in;
      issue_ff <= issue_in;
      tag_ff <= tag_in;
      picked_ff <= picked_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      found_ff <= found_in;
      pass_ff <= pass_in;
      sum_ff <= sum_in;
   end
endmodule

### rtl/dcsum_divider.sv
// Restoring divider: one quotient bit per cycle, floor of the sum over the pick count.
module dcsum_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  dcsum_pkg::sum_type  dividend,
   input  dcsum_pkg::half_type divisor,
   output logic                done,
   output dcsum_pkg::adc_type  quotient
);
   import dcsum_pkg::*;

   div_state_type              state_ff, state_in;
   sum_type                    quo_ff, quo_in;
   half_type                   rem_ff, rem_in;
   logic [DIV_STEP_BITS-1:0]   step_ff, step_in;
   logic                       done_ff, done_in;

   logic [HALF_BITS:0]         shifted;
   logic [HALF_BITS:0]         diff;
   logic                       fits;

   assign done = done_ff;
   assign quotient = quo_ff[ADC_BITS-1:0];

   // Shift one dividend bit into the remainder and subtract where it fits.
   always_comb begin
      state_in = state_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      done_in = 1'b0;

      shifted = {rem_ff, quo_ff[SUM_BITS-1]};
      diff = shifted - {1'b0, divisor};
      fits = (shifted >= {1'b0, divisor});

      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               state_in = DIV_RUN;
               quo_in = dividend;
               rem_in = '0;
               step_in = '0;
            end
         end
         DIV_RUN: begin
            rem_in = fits ? diff[HALF_BITS-1:0] : shifted[HALF_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], fits};
            step_in = step_ff + DIV_STEP_BITS'(1);
            if (step_ff == DIV_STEP_BITS'(SUM_BITS - 1)) begin
               state_in = DIV_IDLE;
               done_in = 1'b1;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
   end
endmodule

### rtl/duty_cycled_sensor_upper_half_mean_top.sv
// Duty-cycled sensor sequencer with upper-half mean over each sample burst.
// Timing: a tick that ends no burst gives its result on the next cycle; a burst-ending tick
// gives its result once the selection unit, with one memory scan per picked sample, and the
// bit-serial divider have run.
// Throughput: one tick per cycle outside burst ends, while the receiver takes the results.
// Reset: registers take their default values, the initial warm-up starts, the sample
// store is not cleared because only entries written in the current burst are read.
module duty_cycled_sensor_upper_half_mean_top (
   input  logic                                   clock,
   input  logic                                   reset,
   dcsum_req_if.sink                              req_if,
   dcsum_rsp_if.source                            rsp_if,
   input  logic                                   csr_we,
   input  logic [dcsum_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dcsum_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import dcsum_pkg::*;

   // Configuration registers.
   time_type                warm_ff;
   time_type                interval_ff;
   time_type                sleep_ff;
   logic [SCNT_BITS-1:0]    scount_ff;

   // Sequencer state.
   ctl_state_type           state_ff, state_in;
   phase_type               phase_ff, phase_in;
   time_type                remaining_ff, remaining_in;
   cnt_type                 count_ff, count_in;
   half_type                half_ff, half_in;
   adc_type                 avg_ff, avg_in;
   logic                    avg_valid_ff, avg_valid_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_power_ff, out_power_in;
   logic                    out_taken_ff, out_taken_in;
   logic                    out_fresh_ff, out_fresh_in;
   logic                    out_avg_valid_ff, out_avg_valid_in;
   adc_type                 out_avg_ff, out_avg_in;

   logic                    slot_free;
   logic                    accept;
   logic                    out_load;
   logic                    taken;
   logic                    fresh;
   logic                    ram_we;
   cnt_type                 count_next;
   cnt_type                 size;
   logic                    sel_start;
   sel_cmd_type             sel_cmd;
   logic [IDX_BITS-1:0]     rd_addr;
   adc_type                 rd_data;
   logic                    sel_done;
   sum_type                 sel_sum;
   logic                    div_done;
   adc_type                 div_quotient;

   dcsum_sample_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (req_if.adc_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dcsum_select u_select (
      .clock   (clock),
      .reset   (reset),
      .start   (sel_start),
      .cmd     (sel_cmd),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (sel_done),
      .sum     (sel_sum)
   );

   dcsum_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (sel_done),
      .dividend (sel_sum),
      .divisor  (half_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.power_on = out_power_ff;
   assign rsp_if.sample_taken = out_taken_ff;
   assign rsp_if.new_average = out_fresh_ff;
   assign rsp_if.average_valid = out_avg_valid_ff;
   assign rsp_if.average_value = out_avg_ff;

   // Register writes; an index beyond the list is ignored. The first warm-up length
   // only matters at reset, which restores its default, so a write to it has no effect.
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= WARM_RESET;
         interval_ff <= INTERVAL_RESET;
         sleep_ff <= SLEEP_RESET;
         scount_ff <= COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INIT_WARM: ;
            CSR_WARM:      warm_ff <= TIME_BITS'(csr_wdata);
            CSR_INTERVAL:  interval_ff <= TIME_BITS'(csr_wdata);
            CSR_SLEEP:     sleep_ff <= TIME_BITS'(csr_wdata);
            CSR_COUNT:     scount_ff <= csr_wdata[SCNT_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // Tick sequencing: count down the running wait, act when it ends, and hand a
   // finished burst to the selection unit and divider before the result is shown.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      remaining_in = remaining_ff;
      count_in = count_ff;
      half_in = half_ff;
      avg_in = avg_ff;
      avg_valid_in = avg_valid_ff;
      out_load = 1'b0;
      taken = 1'b0;
      fresh = 1'b0;
      ram_we = 1'b0;
      sel_start = 1'b0;

      size = burst_size(scount_ff);
      count_next = count_ff;
      slot_free = !rsp_valid_ff || rsp_if.ready;
      req_if.ready = (state_ff == CTL_IDLE) && slot_free;
      accept = req_if.valid && req_if.ready;
      sel_cmd.count = count_ff;
      sel_cmd.half = half_ff;

      case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               if (remaining_ff > TIME_BITS'(1)) begin
                  remaining_in = remaining_ff - TIME_BITS'(1);
                  out_load = 1'b1;
               end else if ((phase_ff == PH_INIT_WARM) || (phase_ff == PH_SLEEP)) begin
                  phase_in = PH_WARM;
                  remaining_in = warm_ff;
                  out_load = 1'b1;
               end else begin
                  ram_we = (count_ff < CNT_BITS'(MAX_SAMPLES));
                  count_next = count_ff + CNT_BITS'(ram_we);
                  taken = 1'b1;
                  if (count_next >= size) begin
                     half_in = HALF_BITS'(size >> 1);
                     sel_cmd.count = count_next;
                     sel_cmd.half = HALF_BITS'(size >> 1);
                     sel_start = 1'b1;
                     count_in = '0;
                     phase_in = PH_SLEEP;
                     remaining_in = sleep_ff;
                     state_in = CTL_SUM;
                  end else begin
                     count_in = count_next;
                     phase_in = PH_SAMPLE;
                     remaining_in = interval_ff;
                     out_load = 1'b1;
                  end
               end
            end
         end
         CTL_SUM: begin
            if (sel_done) begin
               state_in = CTL_DIV;
            end
         end
         CTL_DIV: begin
            if (div_done) begin
               avg_in = div_quotient;
               avg_valid_in = 1'b1;
               state_in = CTL_OUT;
            end
         end
         CTL_OUT: begin
            if (slot_free) begin
               taken = 1'b1;
               fresh = 1'b1;
               out_load = 1'b1;
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase

      // Result register load and release.
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);
      out_power_in = (phase_in != PH_SLEEP);
      out_taken_in = taken;
      out_fresh_in = fresh;
      out_avg_valid_in = avg_valid_in;
      out_avg_in = avg_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         phase_ff <= PH_INIT_WARM;
         remaining_ff <= INIT_WARM_RESET;
         count_ff <= '0;
         avg_ff <= '0;
         avg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         remaining_ff <= remaining_in;
         count_ff <= count_in;
         avg_ff <= avg_in;
         avg_valid_ff <= avg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      half_ff <= half_in;
      if (out_load) begin
         out_power_ff <= out_power_in;
         out_taken_ff <= out_taken_in;
         out_fresh_ff <= out_fresh_in;
         out_avg_valid_ff <= out_avg_valid_in;
         out_avg_ff <= out_avg_in;
      end
   end
endmodule

### tb/sv/tb.sv
// Self-checking testbench of the duty-cycled sensor sampler with upper-half burst mean.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dcsum_pkg::*;

   // Receiver hold-off that lets the block fill up and stall its input.
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 200;
   localparam logic [CSR_INDEX_BITS-1:0] LAST_INDEX = '1;

   typedef struct packed {
      logic    power_on;
      logic    sample_taken;
      logic    new_average;
      logic    average_valid;
      adc_type average_value;
   } tick_status_type;

   // Tracks the sampler state, predicts the status of every tick and checks results.
   class sensor_tracker;
      time_type             first_warm_len;
      time_type             warm_len;
      time_type             interval_len;
      time_type             sleep_len;
      logic [SCNT_BITS-1:0] burst_reg;
      phase_type            phase;
      time_type             remaining;
      adc_type              readings[MAX_SAMPLES];
      int unsigned          held;
      adc_type              mean_reg;
      logic                 mean_seen;
      tick_status_type      expected_status[$];
      int                   failures;

      function new();
         first_warm_len = INIT_WARM_RESET;
         warm_len = WARM_RESET;
         interval_len = INTERVAL_RESET;
         sleep_len = SLEEP_RESET;
         burst_reg = COUNT_RESET;
         phase = PH_INIT_WARM;
         remaining = INIT_WARM_RESET;
         held = 0;
         mean_reg = '0;
         mean_seen = 1'b0;
         failures = 0;
      endfunction

      // Register writes only change the length of waits started later.
      function void set_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_INIT_WARM: first_warm_len = data;
            CSR_WARM: warm_len = data;
            CSR_INTERVAL: interval_len = data;
            CSR_SLEEP: sleep_len = data;
            CSR_COUNT: burst_reg = data[SCNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // One accepted tick: advance the wait, store or average, and queue the status.
      function void note_tick(adc_type reading);
         tick_status_type st;
         int unsigned     size;
         int unsigned     half;
         int unsigned     total;
         int unsigned     picks[$];
         st = '0;
         if (remaining > 1) begin
            remaining = remaining - 1'b1;
         end else if (phase == PH_INIT_WARM || phase == PH_SLEEP) begin
            phase = PH_WARM;
            remaining = warm_len;
         end else begin
            size = burst_reg;
            if (size < 2) size = 2;
            if (size > MAX_SAMPLES) size = MAX_SAMPLES;
            if (held < MAX_SAMPLES) begin
               readings[held] = reading;
               held++;
            end
            st.sample_taken = 1'b1;
            if (held >= size) begin
               // Mean of the largest size/2 readings stored, rounded down.
               for (int i = 0; i < held; i++) picks.insert(picks.size(), readings[i]);
               picks.rsort();
               half = size / 2;
               total = 0;
               for (int i = 0; i < half; i++) total += picks[i];
               mean_reg = adc_type'(total / half);
               mean_seen = 1'b1;
               st.new_average = 1'b1;
               held = 0;
               phase = PH_SLEEP;
               remaining = sleep_len;
            end else begin
               phase = PH_SAMPLE;
               remaining = interval_len;
            end
         end
         st.power_on = (phase != PH_SLEEP);
         st.average_valid = mean_seen;
         st.average_value = mean_reg;
         expected_status.insert(expected_status.size(), st);
      endfunction

      // Compare one result transfer with the oldest predicted status.
      function void check_status(tick_status_type got);
         tick_status_type want;
         if (expected_status.size() == 0) begin
            $error("Result transfer with no tick awaiting a result");
            failures++;
            return;
         end
         want = expected_status.pop_front();
         if (got.power_on !== want.power_on) begin
            $error("power_on: expected %0d, actual %0d", want.power_on, got.power_on);
            failures++;
         end
         if (got.sample_taken !== want.sample_taken) begin
            $error("sample_taken: expected %0d, actual %0d", want.sample_taken,
                   got.sample_taken);
            failures++;
         end
         if (got.new_average !== want.new_average) begin
            $error("new_average: expected %0d, actual %0d", want.new_average, got.new_average);
            failures++;
         end
         if (got.average_valid !== want.average_valid) begin
            $error("average_valid: expected %0d, actual %0d", want.average_valid,
                   got.average_valid);
            failures++;
         end
         if (got.average_value !== want.average_value) begin
            $error("average_value: expected %0d, actual %0d", want.average_value,
                   got.average_value);
            failures++;
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   dcsum_req_if req_ch();
   dcsum_rsp_if rsp_ch();

   sensor_tracker book;
   int            send_gap_max = 16;
   int            take_gap_max = 16;
   bit            hold_off_request = 1'b0;

   duty_cycled_sensor_upper_half_mean_top uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Clock with a 10 ns period.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one tick after a random gap and hold it until the transfer.
   task automatic send_tick(input adc_type reading);
      int gap;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.adc_sample <= reading;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      book.note_tick(reading);
   endtask

   // Ticks with random readings, weighted toward the extremes and near-ties.
   task automatic run_ticks(input int ticks);
      adc_type reading;
      repeat (ticks) begin
         case ($urandom_range(0, 5))
            0: reading = '0;
            1: reading = '1;
            2: reading = adc_type'($urandom_range(2040, 2055));
            default: reading = adc_type'($urandom);
         endcase
         send_tick(reading);
      end
   endtask

   // Stop offering and wait until every predicted status has been received.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      book.set_reg(index, data);
      @(posedge clock);
   endtask

   // Write every register, plus one unmapped index that must be ignored.
   task automatic apply_setting(input time_type first_warm, input time_type warm,
                                input time_type interval, input time_type pause,
                                input logic [CSR_DATA_BITS-1:0] burst_word);
      write_reg(CSR_INIT_WARM, first_warm);
      write_reg(CSR_WARM, warm);
      write_reg(CSR_INTERVAL, interval);
      write_reg(CSR_SLEEP, pause);
      write_reg(CSR_COUNT, burst_word);
      write_reg(CSR_INDEX_BITS'($urandom_range(int'(CSR_COUNT) + 1, int'(LAST_INDEX))),
                CSR_DATA_BITS'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic time_type pick_duration();
      if ($urandom_range(0, 9) == 0) return time_type'($urandom_range(0, 40));
      return time_type'($urandom_range(0, 3));
   endfunction

   // Result side: random stalls per transfer, plus one long hold-off on request.
   initial begin
      int              stall;
      tick_status_type got;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{power_on: rsp_ch.power_on, sample_taken: rsp_ch.sample_taken,
                    new_average: rsp_ch.new_average, average_valid: rsp_ch.average_valid,
                    average_value: rsp_ch.average_value};
            book.check_status(got);
            stall = (take_gap_max == 0) ? 0 : $urandom_range(0, take_gap_max);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      adc_type corner_readings[14] = '{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h123,
                                       12'h000, 12'h000, 12'h000, 12'h000, 12'h456,
                                       12'hAAA, 12'h555, 12'hFFF, 12'h001};
      adc_type wide_burst[7] = '{12'h321, 12'h100, 12'h7FF, 12'h800, 12'h7FF, 12'h200,
                                 12'h300};
      logic [SCNT_BITS-1:0] burst;
      book = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.adc_sample <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register values after reset: first warm-up, warm-up and a burst of ten.
      run_ticks(100);
      wait_idle();

      // Zero-length waits with bursts of four; the sleep started at reset values runs out.
      apply_setting('0, '0, '0, '0, CSR_DATA_BITS'(4));
      run_ticks(59);
      foreach (corner_readings[i]) send_tick(corner_readings[i]);
      wait_idle();

      // Largest burst size, then lowered mid-burst to a value below the minimum.
      apply_setting('0, '0, '0, '0, CSR_DATA_BITS'(MAX_SAMPLES));
      foreach (wide_burst[i]) send_tick(wide_burst[i]);
      wait_idle();
      apply_setting('0, '0, '0, '0, 16'hFFE0);
      send_tick(12'h050);
      wait_idle();

      // Random settings; one phase keeps the result side blocked for a long time.
      for (int p = 0; p < 8; p++) begin
         if ($urandom_range(0, 3) == 0) burst = SCNT_BITS'($urandom_range(0, 31));
         else burst = SCNT_BITS'($urandom_range(2, MAX_SAMPLES));
         apply_setting(time_type'($urandom), pick_duration(), pick_duration(),
                       pick_duration(), {11'($urandom), burst});
         send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
         if (p == 2) begin
            send_gap_max = 0;
            hold_off_request = 1'b1;
         end
         run_ticks(25);
         wait_idle();
      end

      // Longest waits and an oversized burst setting; the next wait loads the maximum.
      send_gap_max = 16;
      take_gap_max = 16;
      apply_setting('1, '1, '1, '1, CSR_DATA_BITS'(31));
      run_ticks(40);
      wait_idle();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
